[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the bitmap block allocator with file table.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int BM_WORD_W = 16;
  localparam int BM_BIT_W  = 4;

  typedef enum logic [2:0] {
    CMD_FORMAT = 3'd0,
    CMD_CREATE = 3'd1,
    CMD_ADD    = 3'd2,
    CMD_FREE   = 3'd3,
    CMD_DELETE = 3'd4,
    CMD_LOOKUP = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] file_id;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [10:0] block;
    logic [3:0]  block_count;
  } out_t;

  typedef enum logic [1:0] {
    BM_OP_CLEAR,
    BM_OP_ALLOC,
    BM_OP_RELEASE
  } bm_op_e;

  typedef struct packed {
    logic   start;
    bm_op_e op;
  } bm_req_t;

  typedef struct packed {
    logic done;
    logic found;
  } bm_rsp_t;

  typedef enum logic [2:0] {
    BM_IDLE,
    BM_CLEAR,
    BM_SCAN,
    BM_REL_RD,
    BM_REL_WR
  } bm_state_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FMT_GO,
    S_FMT_WAIT,
    S_ALC_GO,
    S_ALC_WAIT,
    S_FIND_RD,
    S_FIND_CHK,
    S_REL_RD,
    S_REL_GO,
    S_REL_WAIT,
    S_LCP_RD,
    S_LCP_WR,
    S_ECP_RD,
    S_ECP_WR,
    S_OUT
  } state_e;

endpackage

[rtl/bba_bitmap.sv]
// ----------------------------------------------------------------------------
// bba_bitmap
// Free-block bitmap in 16-bit words: clear sweep, first-fit scan, release.
// ----------------------------------------------------------------------------
module bba_bitmap import bba_pkg::*; #(
  parameter int NUM_BLOCKS = 2048,
  localparam int NWORDS = (NUM_BLOCKS + BM_WORD_W - 1) / BM_WORD_W,
  localparam int WAW = (NWORDS > 1) ? $clog2(NWORDS) : 1,
  localparam int BXW = WAW + BM_BIT_W
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bm_req_t        req_i,
  input  logic [BXW-1:0] blk_i,
  output bm_rsp_t        rsp_o,
  output logic [BXW-1:0] blk_o
);

  bm_state_e state_q, state_d;
  logic [WAW:0] ptr_q, ptr_d;
  logic chk_q, chk_d;
  logic [WAW-1:0] caddr_q, caddr_d;
  logic [BXW-1:0] blk_q, blk_d;

  logic [BM_WORD_W-1:0] mem [NWORDS];
  logic [BM_WORD_W-1:0] rdata_q;
  logic re, we;
  logic [WAW-1:0] raddr, waddr;
  logic [BM_WORD_W-1:0] wdata;

  logic [BM_WORD_W-1:0] clr_word;
  logic [BM_BIT_W-1:0] low_bit;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // initial word content: blocks 0 and 1 used, blocks past the end never free
  always_comb begin
    logic [BXW:0] idx;
    clr_word = '0;
    for (int b = 0; b < BM_WORD_W; b++) begin
      idx = {1'b0, ptr_q[WAW-1:0], BM_BIT_W'(b)};
      clr_word[b] = (idx >= (BXW+1)'(2)) && (idx < (BXW+1)'(NUM_BLOCKS));
    end
  end

  always_comb begin
    low_bit = '0;
    for (int b = BM_WORD_W - 1; b >= 0; b--) begin
      if (rdata_q[b]) begin
        low_bit = BM_BIT_W'(b);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BM_IDLE;
      ptr_q   <= '0;
      chk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      chk_q   <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    caddr_q <= caddr_d;
    blk_q   <= blk_d;
  end

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    chk_d   = chk_q;
    caddr_d = caddr_q;
    blk_d   = blk_q;
    re      = 1'b0;
    raddr   = ptr_q[WAW-1:0];
    we      = 1'b0;
    waddr   = ptr_q[WAW-1:0];
    wdata   = clr_word;
    rsp_o   = '0;
    blk_o   = blk_q;
    unique case (state_q)
      BM_IDLE: begin
        if (req_i.start) begin
          ptr_d = '0;
          chk_d = 1'b0;
          blk_d = blk_i;
          unique case (req_i.op)
            BM_OP_CLEAR:   state_d = BM_CLEAR;
            BM_OP_ALLOC:   state_d = BM_SCAN;
            BM_OP_RELEASE: state_d = BM_REL_RD;
            default:       state_d = BM_IDLE;
          endcase
        end
      end
      BM_CLEAR: begin
        we = 1'b1;
        if (ptr_q == (WAW+1)'(NWORDS - 1)) begin
          rsp_o.done = 1'b1;
          state_d    = BM_IDLE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      BM_SCAN: begin
        // one word read per cycle, the previous word checked meanwhile
        re      = ptr_q < (WAW+1)'(NWORDS);
        chk_d   = re;
        caddr_d = ptr_q[WAW-1:0];
        if (re) begin
          ptr_d = ptr_q + 1'b1;
        end
        if (chk_q && (|rdata_q)) begin
          we          = 1'b1;
          waddr       = caddr_q;
          wdata       = rdata_q & ~(BM_WORD_W'(1) << low_bit);
          blk_d       = {caddr_q, low_bit};
          blk_o       = {caddr_q, low_bit};
          rsp_o.done  = 1'b1;
          rsp_o.found = 1'b1;
          state_d     = BM_IDLE;
        end else if (ptr_q == (WAW+1)'(NWORDS)) begin
          rsp_o.done = 1'b1;
          state_d    = BM_IDLE;
        end
      end
      BM_REL_RD: begin
        re      = 1'b1;
        raddr   = blk_q[BXW-1:BM_BIT_W];
        state_d = BM_REL_WR;
      end
      BM_REL_WR: begin
        we         = 1'b1;
        waddr      = blk_q[BXW-1:BM_BIT_W];
        wdata      = rdata_q | (BM_WORD_W'(1) << blk_q[BM_BIT_W-1:0]);
        rsp_o.done = 1'b1;
        state_d    = BM_IDLE;
      end
      default: state_d = BM_IDLE;
    endcase
  end

endmodule

[rtl/bitmap_block_allocator_with_file_table.sv]
// ----------------------------------------------------------------------------
// bitmap_block_allocator_with_file_table
// First-fit block allocator with a free bitmap and a table of files.
// ----------------------------------------------------------------------------
// One command item at a time: the block stalls its input from acceptance until
// the result is placed in the output register, and the next item may enter
// while that result still waits. After reset (and on format) the bitmap is
// swept one 16-bit word per cycle, with the input stalled. Allocation scans
// the bitmap one word per cycle from block 0 for create and add_block.
// File lookups read the table one entry at a time from the front; releasing
// a file's list returns its blocks to the bitmap one at a time from the end,
// and delete then moves every later entry and its list down by one entry,
// with a read and a write per moved word.
module bitmap_block_allocator_with_file_table import bba_pkg::*; #(
  parameter int NUM_BLOCKS          = 2048,
  parameter int MAX_FILES           = 16,
  parameter int MAX_BLOCKS_PER_FILE = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int NWORDS = (NUM_BLOCKS + BM_WORD_W - 1) / BM_WORD_W;
  localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BXW    = WAW + BM_BIT_W;
  localparam int CW     = $clog2(MAX_BLOCKS_PER_FILE + 1);
  localparam int FW     = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int FCW    = $clog2(MAX_FILES + 1);
  localparam int NL     = MAX_FILES * MAX_BLOCKS_PER_FILE;
  localparam int LAW    = (NL > 1) ? $clog2(NL) : 1;
  localparam int LAX    = LAW + 1;

  state_e state_q, state_d;
  logic init_q, init_d;
  logic [2:0] cmd_q, cmd_d;
  logic [15:0] id_q, id_d;
  logic [FCW-1:0] fc_q, fc_d;
  logic [FCW-1:0] i_q, i_d;
  logic [FW-1:0] f_q, f_d;
  logic [CW-1:0] h_q, h_d;
  logic [LAX-1:0] a_q, a_d;
  out_t res_q, res_d;
  out_t out_q;
  logic out_valid_q;
  logic out_load;

  // file table entries
  logic [15:0]   ent_id_mem  [MAX_FILES];
  logic [CW-1:0] ent_cnt_mem [MAX_FILES];
  logic [15:0]   ent_rid_q;
  logic [CW-1:0] ent_rcnt_q;
  logic ent_we;
  logic [FW-1:0] ent_waddr, ent_raddr;
  logic [15:0] ent_wid;
  logic [CW-1:0] ent_wcnt;

  // block lists, MAX_BLOCKS_PER_FILE words per entry
  logic [BXW-1:0] lst_mem [NL];
  logic [BXW-1:0] lst_rdata_q;
  logic lst_we;
  logic [LAW-1:0] lst_waddr, lst_raddr;
  logic [BXW-1:0] lst_wdata;

  bm_req_t bm_req;
  bm_rsp_t bm_rsp;
  logic [BXW-1:0] bm_blk_in, bm_blk;

  logic [LAW-1:0] base, new_base;
  logic [CW-1:0] h_inc;
  logic [LAX-1:0] lcp_end, lcp_waddr, lcp_start;
  logic [FCW-1:0] k_prev;
  logic [CW+3:0] hinc_ext;
  logic [BXW+10:0] blk_ext;

  bba_bitmap #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_bitmap (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (bm_req),
    .blk_i (bm_blk_in),
    .rsp_o (bm_rsp),
    .blk_o (bm_blk)
  );

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_id_mem[ent_waddr]  <= ent_wid;
      ent_cnt_mem[ent_waddr] <= ent_wcnt;
    end
    ent_rid_q  <= ent_id_mem[ent_raddr];
    ent_rcnt_q <= ent_cnt_mem[ent_raddr];
    if (lst_we) begin
      lst_mem[lst_waddr] <= lst_wdata;
    end
    lst_rdata_q <= lst_mem[lst_raddr];
  end

  assign base      = LAW'(f_q) * LAW'(MAX_BLOCKS_PER_FILE);
  assign new_base  = LAW'(fc_q[FW-1:0]) * LAW'(MAX_BLOCKS_PER_FILE);
  assign h_inc     = h_q + 1'b1;
  assign lcp_end   = LAX'(fc_q) * LAX'(MAX_BLOCKS_PER_FILE);
  assign lcp_start = LAX'(f_q) * LAX'(MAX_BLOCKS_PER_FILE) + LAX'(MAX_BLOCKS_PER_FILE);
  assign lcp_waddr = a_q - LAX'(MAX_BLOCKS_PER_FILE);
  assign k_prev    = i_q - 1'b1;
  assign hinc_ext  = {4'b0, h_inc};
  assign blk_ext   = {11'b0, bm_blk};

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FMT_GO;
      init_q      <= 1'b1;
      fc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      fc_q    <= fc_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    id_q  <= id_d;
    i_q   <= i_d;
    f_q   <= f_d;
    h_q   <= h_d;
    a_q   <= a_d;
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    init_d    = init_q;
    cmd_d     = cmd_q;
    id_d      = id_q;
    fc_d      = fc_q;
    i_d       = i_q;
    f_d       = f_q;
    h_d       = h_q;
    a_d       = a_q;
    res_d     = res_q;
    bm_req    = '0;
    bm_req.op = BM_OP_CLEAR;
    bm_blk_in = lst_rdata_q;
    ent_we    = 1'b0;
    ent_waddr = f_q;
    ent_raddr = i_q[FW-1:0];
    ent_wid   = id_q;
    ent_wcnt  = h_q;
    lst_we    = 1'b0;
    lst_waddr = base + LAW'(h_q);
    lst_raddr = base + LAW'(h_q);
    lst_wdata = bm_blk;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = in_data_i.cmd;
          id_d  = in_data_i.file_id;
          res_d = '0;
          i_d   = '0;
          unique case (in_data_i.cmd)
            CMD_FORMAT: state_d = S_FMT_GO;
            CMD_CREATE: begin
              if (fc_q == FCW'(MAX_FILES)) begin
                state_d = S_OUT;
              end else begin
                state_d = S_ALC_GO;
              end
            end
            CMD_ADD, CMD_FREE, CMD_DELETE, CMD_LOOKUP: state_d = S_FIND_RD;
            default: state_d = S_OUT;
          endcase
        end
      end
      S_FMT_GO: begin
        bm_req.start = 1'b1;
        bm_req.op    = BM_OP_CLEAR;
        state_d      = S_FMT_WAIT;
      end
      S_FMT_WAIT: begin
        if (bm_rsp.done) begin
          fc_d = '0;
          if (init_q) begin
            init_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            res_d    = '0;
            res_d.ok = 1'b1;
            state_d  = S_OUT;
          end
        end
      end
      S_ALC_GO: begin
        bm_req.start = 1'b1;
        bm_req.op    = BM_OP_ALLOC;
        state_d      = S_ALC_WAIT;
      end
      S_ALC_WAIT: begin
        if (bm_rsp.done) begin
          state_d = S_OUT;
          if (cmd_q == CMD_CREATE) begin
            if (bm_rsp.found) begin
              ent_we            = 1'b1;
              ent_waddr         = fc_q[FW-1:0];
              ent_wcnt          = CW'(1);
              lst_we            = 1'b1;
              lst_waddr         = new_base;
              fc_d              = fc_q + 1'b1;
              res_d.ok          = 1'b1;
              res_d.block       = blk_ext[10:0];
              res_d.block_count = 4'd1;
            end
          end else if (bm_rsp.found) begin
            ent_we            = 1'b1;
            ent_wcnt          = h_inc;
            lst_we            = 1'b1;
            res_d.ok          = 1'b1;
            res_d.block       = blk_ext[10:0];
            res_d.block_count = hinc_ext[3:0];
          end
        end
      end
      S_FIND_RD: begin
        if (i_q == fc_q) begin
          state_d = S_OUT;
        end else begin
          state_d = S_FIND_CHK;
        end
      end
      S_FIND_CHK: begin
        if (ent_rid_q == id_q) begin
          f_d = i_q[FW-1:0];
          h_d = ent_rcnt_q;
          priority case (cmd_q)
            CMD_LOOKUP: begin
              res_d.ok          = 1'b1;
              res_d.block_count = 4'({4'b0, ent_rcnt_q});
              state_d           = S_OUT;
            end
            CMD_ADD: begin
              res_d.block_count = 4'({4'b0, ent_rcnt_q});
              if (ent_rcnt_q == CW'(MAX_BLOCKS_PER_FILE)) begin
                state_d = S_OUT;
              end else begin
                state_d = S_ALC_GO;
              end
            end
            default: state_d = S_REL_RD;
          endcase
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_FIND_RD;
        end
      end
      S_REL_RD: begin
        // walk the list from its end, one block per pass
        if (h_q == '0) begin
          res_d.ok = 1'b1;
          if (cmd_q == CMD_FREE) begin
            ent_we   = 1'b1;
            ent_wcnt = '0;
            state_d  = S_OUT;
          end else begin
            a_d     = lcp_start;
            state_d = S_LCP_RD;
          end
        end else begin
          h_d       = h_q - 1'b1;
          lst_raddr = base + LAW'(h_q - 1'b1);
          state_d   = S_REL_GO;
        end
      end
      S_REL_GO: begin
        bm_req.start = 1'b1;
        bm_req.op    = BM_OP_RELEASE;
        state_d      = S_REL_WAIT;
      end
      S_REL_WAIT: begin
        if (bm_rsp.done) begin
          state_d = S_REL_RD;
        end
      end
      S_LCP_RD: begin
        // move the lists of later entries down by one entry
        lst_raddr = a_q[LAW-1:0];
        if (a_q == lcp_end) begin
          i_d     = FCW'(f_q) + 1'b1;
          state_d = S_ECP_RD;
        end else begin
          state_d = S_LCP_WR;
        end
      end
      S_LCP_WR: begin
        lst_we    = 1'b1;
        lst_waddr = lcp_waddr[LAW-1:0];
        lst_wdata = lst_rdata_q;
        a_d       = a_q + 1'b1;
        state_d   = S_LCP_RD;
      end
      S_ECP_RD: begin
        if (i_q == fc_q) begin
          fc_d    = fc_q - 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_ECP_WR;
        end
      end
      S_ECP_WR: begin
        ent_we    = 1'b1;
        ent_waddr = k_prev[FW-1:0];
        ent_wid   = ent_rid_q;
        ent_wcnt  = ent_rcnt_q;
        i_d       = i_q + 1'b1;
        state_d   = S_ECP_RD;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[dv/bba_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bba_checker
// Watches both channels of the block allocator, keeps its own copy of the
// free map and file table, and compares every result with the predicted one.
// ----------------------------------------------------------------------------
module bba_checker import bba_pkg::*; #(
  parameter int NUM_BLOCKS          = 2048,
  parameter int MAX_FILES           = 16,
  parameter int MAX_BLOCKS_PER_FILE = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   results_seen_o
);

  bit          used_map [NUM_BLOCKS];
  int          n_files;
  logic [15:0] ids [MAX_FILES];
  int          held [MAX_FILES];
  int          lists [MAX_FILES][MAX_BLOCKS_PER_FILE];
  out_t        expected_q [$];

  function automatic void wipe_disk();
    for (int b = 0; b < NUM_BLOCKS; b++) used_map[b] = (b < 2);
    n_files = 0;
  endfunction

  function automatic bit grab_block(output int blk);
    blk = 0;
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      if (!used_map[b]) begin
        used_map[b] = 1;
        blk = b;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic int find_entry(logic [15:0] id);
    for (int i = 0; i < n_files; i++) if (ids[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_blocks(int f);
    while (held[f] > 0) begin
      held[f]--;
      used_map[lists[f][held[f]]] = 0;
    end
  endfunction

  function automatic out_t predict_result(in_t it);
    out_t r;
    int   f;
    int   blk;
    r = '0;
    unique case (it.cmd)
      CMD_FORMAT: begin
        wipe_disk();
        r.ok = 1'b1;
      end
      CMD_CREATE: begin
        if (n_files < MAX_FILES && grab_block(blk)) begin
          ids[n_files] = it.file_id;
          lists[n_files][0] = blk;
          held[n_files] = 1;
          n_files++;
          r.ok = 1'b1;
          r.block = 11'(blk);
          r.block_count = 4'd1;
        end
      end
      CMD_ADD: begin
        f = find_entry(it.file_id);
        if (f >= 0) begin
          r.block_count = 4'(held[f]);
          if (held[f] < MAX_BLOCKS_PER_FILE && grab_block(blk)) begin
            lists[f][held[f]] = blk;
            held[f]++;
            r.ok = 1'b1;
            r.block = 11'(blk);
            r.block_count = 4'(held[f]);
          end
        end
      end
      CMD_FREE: begin
        f = find_entry(it.file_id);
        if (f >= 0) begin
          drop_blocks(f);
          r.ok = 1'b1;
        end
      end
      CMD_DELETE: begin
        f = find_entry(it.file_id);
        if (f >= 0) begin
          drop_blocks(f);
          for (int k = f; k + 1 < n_files; k++) begin
            ids[k] = ids[k+1];
            held[k] = held[k+1];
            lists[k] = lists[k+1];
          end
          n_files--;
          r.ok = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        f = find_entry(it.file_id);
        if (f >= 0) begin
          r.ok = 1'b1;
          r.block_count = 4'(held[f]);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      wipe_disk();
      expected_q.delete();
      fail_count_o <= 0;
      results_seen_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_seen_o <= results_seen_o + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.ok !== out_data_i.ok || want.block !== out_data_i.block ||
              want.block_count !== out_data_i.block_count) begin
            $display("%0t: exp ok=%0d blk=%0d cnt=%0d got ok=%0d blk=%0d cnt=%0d",
                     $time, want.ok, want.block, want.block_count,
                     out_data_i.ok, out_data_i.block, out_data_i.block_count);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_result(in_data_i));
    end
  end

  assign pending_o = expected_q.size();

endmodule

[dv/tb_bitmap_block_allocator_with_file_table.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_block_allocator_with_file_table
// Directed and random command streams for the block allocator, with random
// idling on both channels, a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_bitmap_block_allocator_with_file_table;
  import bba_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  out_t out_data_o;
  int   fail_count;
  int   pending;
  int   results_seen;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_recv = 0;
  int   cycles = 0;
  int   items_sent = 0;
  logic [15:0] id_pool [8] = '{16'h0000, 16'hffff, 16'h0001, 16'h8000,
                                16'h1234, 16'h00aa, 16'h5555, 16'h7fff};

  always #4 clk_i = ~clk_i;

  bitmap_block_allocator_with_file_table dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  bba_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= hold_recv || ($urandom_range(99) < recv_idle_pct);
  end

  // one item: optional idle gap, then hold valid until accepted
  task automatic send_item(cmd_e c, logic [15:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= '{cmd: c, file_id: id};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_raw(logic [2:0] c, logic [15:0] id);
    send_item(cmd_e'(c), id);
  endtask

  task automatic wait_drained();
    in_valid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic random_items(int n);
    int          r;
    logic [15:0] id;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      id = ($urandom_range(9) == 0) ? 16'($urandom) : id_pool[$urandom_range(7)];
      if (r < 2) send_item(CMD_FORMAT, id);
      else if (r < 25) send_item(CMD_CREATE, id);
      else if (r < 55) send_item(CMD_ADD, id);
      else if (r < 65) send_item(CMD_FREE, id);
      else if (r < 77) send_item(CMD_DELETE, id);
      else if (r < 97) send_item(CMD_LOOKUP, id);
      else send_raw(3'($urandom_range(7, 6)), id);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, every command, table and list full, not found
    send_item(CMD_LOOKUP, 16'h0000);
    send_item(CMD_ADD, 16'hffff);
    send_item(CMD_FREE, 16'h0001);
    send_item(CMD_DELETE, 16'h0001);
    send_item(CMD_CREATE, 16'hffff);
    send_item(CMD_CREATE, 16'h0000);
    send_item(CMD_CREATE, 16'hffff);
    for (int i = 0; i < 8; i++) send_item(CMD_ADD, 16'hffff);
    send_item(CMD_LOOKUP, 16'hffff);
    send_item(CMD_FREE, 16'hffff);
    send_item(CMD_ADD, 16'hffff);
    send_item(CMD_DELETE, 16'h0000);
    for (int i = 0; i < 15; i++) send_item(CMD_CREATE, 16'(i * 4369));
    send_item(CMD_DELETE, 16'hffff);
    send_raw(3'd6, 16'h5555);
    send_raw(3'd7, 16'haaaa);
    send_item(CMD_FORMAT, 16'h0000);
    wait_drained();

    send_idle_pct = 22;
    recv_idle_pct = 88;
    random_items(200);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_recv <= 1;
        repeat (300) @(posedge clk_i);
        hold_recv <= 0;
      end
      begin
        random_items(10);
        wait_drained();
      end
    join
    wait_drained();

    send_idle_pct = 88;
    recv_idle_pct = 22;
    random_items(150);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_items(250);
    wait_drained();

    $display("covered %0d items and %0d results over all commands,", items_sent,
             results_seen);
    $display("with full table and list cases, idling and a long output hold-off");
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
